/* hw/rtl/tfnt_pkg.sv */
// ----------------------------------------------------------------------------
// tfnt_pkg
// Types, codes and helpers shared by the flood neighbor tracker.
// ----------------------------------------------------------------------------
package tfnt_pkg;

	localparam int ID_W     = 16;
	localparam int SEQ_W    = 8;
	localparam int CMD_W    = 2;
	localparam int PKT_W    = 8;
	localparam int RAND_W   = 15;
	localparam int ACT_W    = 3;
	localparam int DELAY_W  = 10;

	localparam int NEIGHBOR_SLOTS_DEF     = 28;
	localparam int ORIGIN_CACHE_SLOTS_DEF = 10;

	localparam int DELAY_BASE = 500;
	localparam int DELAY_SPAN = 500;
	// 500 << 6 is the largest multiple step that still fits a 15-bit random value
	localparam int MOD_STEPS  = 6;

	localparam logic [CMD_W-1:0] CMD_RX    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TIMER = 2'd2;

	localparam logic [PKT_W-1:0] PKT_PING  = 8'd1;
	localparam logic [PKT_W-1:0] PKT_REPLY = 8'd2;

	localparam logic [ACT_W-1:0] ACT_NONE  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_FWD   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_PING  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_HDR   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_ENTRY = 3'd4;

	// result kinds loaded into the output register
	localparam logic [1:0] RES_PKT   = 2'd0;
	localparam logic [1:0] RES_START = 2'd1;
	localparam logic [1:0] RES_HDR   = 2'd2;
	localparam logic [1:0] RES_ENTRY = 2'd3;

	typedef struct packed {
		logic             take;
		logic             idx_clr;
		logic             idx_inc;
		logic             rd_en;
		logic             tbl_clr;
		logic             seq_adopt;
		logic             seq_inc;
		logic             nbr_add;
		logic             load;
		logic [1:0]       res_sel;
	} tfnt_cmd_t;

	typedef struct packed {
		logic             evt_valid;
		logic [CMD_W-1:0] command;
		logic             is_ping;
		logic             is_reply;
		logic             new_seq;
		logic             idx_end;
		logic             idx_last;
		logic             pend;
		logic             match;
		logic             cnt_zero;
		logic             out_free;
	} tfnt_sts_t;

	// 500 + r mod 500, by restoring compare and subtract
	function automatic logic [DELAY_W-1:0] reply_delay(input logic [RAND_W-1:0] r);
		logic [RAND_W:0] rem;
		logic [RAND_W:0] step;
		rem = {1'b0, r};
		for (int k = MOD_STEPS; k >= 0; k--) begin
			step = (RAND_W+1)'(DELAY_SPAN) << k;
			if (rem >= step) begin
				rem = rem - step;
			end
		end
		return DELAY_W'(DELAY_BASE) + DELAY_W'(rem);
	endfunction

endpackage

/* hw/rtl/tfnt_if.sv */
// ----------------------------------------------------------------------------
// tfnt_if
// Valid/ready channels of the flood neighbor tracker.
// ----------------------------------------------------------------------------
interface tfnt_in_if;
	logic                         valid;
	logic                         ready;
	logic [tfnt_pkg::CMD_W-1:0]   command;
	logic [tfnt_pkg::PKT_W-1:0]   pkt_type;
	logic [tfnt_pkg::SEQ_W-1:0]   seq_no;
	logic [tfnt_pkg::ID_W-1:0]    origin;
	logic [tfnt_pkg::ID_W-1:0]    route;
	logic [tfnt_pkg::RAND_W-1:0]  random_value;

	modport source (output valid, command, pkt_type, seq_no, origin, route, random_value,
		input ready);
	modport sink (input valid, command, pkt_type, seq_no, origin, route, random_value,
		output ready);
endinterface

interface tfnt_out_if #(
	parameter int TOTAL_W = $clog2(tfnt_pkg::NEIGHBOR_SLOTS_DEF + 1)
);
	logic                          valid;
	logic                          ready;
	logic [tfnt_pkg::ACT_W-1:0]    action;
	logic [tfnt_pkg::SEQ_W-1:0]    seq_no_out;
	logic [tfnt_pkg::ID_W-1:0]     origin_out;
	logic [tfnt_pkg::ID_W-1:0]     route_out;
	logic [tfnt_pkg::ID_W-1:0]     neighbor_id;
	logic [TOTAL_W-1:0]            neighbor_total;
	logic                          arm_timer;
	logic [tfnt_pkg::DELAY_W-1:0]  delay_ms;
	logic                          last;

	modport source (output valid, action, seq_no_out, origin_out, route_out, neighbor_id,
		neighbor_total, arm_timer, delay_ms, last, input ready);
	modport sink (input valid, action, seq_no_out, origin_out, route_out, neighbor_id,
		neighbor_total, arm_timer, delay_ms, last, output ready);
endinterface

interface tfnt_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [tfnt_pkg::ID_W-1:0] own_node_id;

	modport source (output valid, own_node_id, input ready);
	modport sink (input valid, own_node_id, output ready);
endinterface

/* hw/rtl/tfnt_ram.sv */
// ----------------------------------------------------------------------------
// tfnt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tfnt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 28,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hw/rtl/tfnt_dp.sv */
// ----------------------------------------------------------------------------
// tfnt_dp
// Datapath: captured word, sequence and neighbor state, origin ring and
// output register.
// ----------------------------------------------------------------------------
module tfnt_dp #(
	parameter int NEIGHBOR_SLOTS     = tfnt_pkg::NEIGHBOR_SLOTS_DEF,
	parameter int ORIGIN_CACHE_SLOTS = tfnt_pkg::ORIGIN_CACHE_SLOTS_DEF,
	localparam int CNT_W  = $clog2(NEIGHBOR_SLOTS + 1),
	localparam int ADDR_W = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1,
	localparam int PTR_W  = (ORIGIN_CACHE_SLOTS > 1) ? $clog2(ORIGIN_CACHE_SLOTS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	tfnt_in_if.sink              evt,
	tfnt_cfg_if.sink             cfg,
	tfnt_out_if.source           res,
	input  tfnt_pkg::tfnt_cmd_t  cmd,
	output tfnt_pkg::tfnt_sts_t  sts
);

	logic [tfnt_pkg::ID_W-1:0]    own_q;
	logic [tfnt_pkg::CMD_W-1:0]   cmd_q;
	logic [tfnt_pkg::PKT_W-1:0]   pkt_q;
	logic [tfnt_pkg::SEQ_W-1:0]   seq_in_q;
	logic [tfnt_pkg::ID_W-1:0]    org_q;
	logic [tfnt_pkg::ID_W-1:0]    rte_q;
	logic [tfnt_pkg::DELAY_W-1:0] delay_q;

	logic [tfnt_pkg::SEQ_W-1:0]   cur_seq_q;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             idx_q;
	logic                         pend_q;
	logic                         fwd_q;
	logic                         arm_q;

	logic [tfnt_pkg::ID_W-1:0]    cache_q [ORIGIN_CACHE_SLOTS];
	logic [ORIGIN_CACHE_SLOTS-1:0] cval_q;
	logic [PTR_W-1:0]             ptr_q;

	logic                         ovalid_q;
	logic [tfnt_pkg::ACT_W-1:0]   oaction_q;
	logic [tfnt_pkg::SEQ_W-1:0]   oseq_q;
	logic [tfnt_pkg::ID_W-1:0]    oorg_q;
	logic [tfnt_pkg::ID_W-1:0]    orte_q;
	logic [tfnt_pkg::ID_W-1:0]    onid_q;
	logic [CNT_W-1:0]             ototal_q;
	logic                         oarm_q;
	logic [tfnt_pkg::DELAY_W-1:0] odelay_q;
	logic                         olast_q;

	logic                         capture;
	logic                         room;
	logic                         cache_hit;
	logic                         fwd_reply;
	logic                         fwd;
	logic                         is_ping;
	logic                         is_reply;
	logic [tfnt_pkg::ID_W-1:0]    rd_data;

	assign evt.ready = cmd.take;
	assign cfg.ready = 1'b1;
	assign capture   = evt.valid && cmd.take;
	assign room      = count_q < CNT_W'(NEIGHBOR_SLOTS);
	assign is_ping   = pkt_q == tfnt_pkg::PKT_PING;
	assign is_reply  = pkt_q == tfnt_pkg::PKT_REPLY;

	always_comb begin
		cache_hit = 1'b0;
		for (int i = 0; i < ORIGIN_CACHE_SLOTS; i++) begin
			if (cval_q[i] && cache_q[i] == org_q) begin
				cache_hit = 1'b1;
			end
		end
	end

	assign fwd_reply = (org_q != own_q) && !cache_hit;
	assign fwd       = is_ping ? fwd_q : fwd_reply;

	tfnt_ram #(
		.WIDTH (tfnt_pkg::ID_W),
		.DEPTH (NEIGHBOR_SLOTS)
	) u_nbr_ram (
		.clk     (clk),
		.wr_en   (cmd.nbr_add && room),
		.wr_addr (count_q[ADDR_W-1:0]),
		.wr_data (rte_q),
		.rd_en   (cmd.rd_en),
		.rd_addr (idx_q[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	always_comb begin
		sts           = '0;
		sts.evt_valid = evt.valid;
		sts.command   = cmd_q;
		sts.is_ping   = is_ping;
		sts.is_reply  = is_reply;
		sts.new_seq   = seq_in_q != cur_seq_q;
		sts.idx_end   = idx_q == count_q;
		sts.idx_last  = ({1'b0, idx_q} + (CNT_W+1)'(1)) == {1'b0, count_q};
		sts.pend      = pend_q;
		sts.match     = pend_q && (rd_data == rte_q);
		sts.cnt_zero  = count_q == '0;
		sts.out_free  = !ovalid_q || res.ready;
	end

	// captured word, no reset needed
	always_ff @(posedge clk) begin
		if (capture) begin
			cmd_q    <= evt.command;
			pkt_q    <= evt.pkt_type;
			seq_in_q <= evt.seq_no;
			org_q    <= evt.origin;
			rte_q    <= evt.route;
			delay_q  <= tfnt_pkg::reply_delay(evt.random_value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q     <= '0;
			cur_seq_q <= '0;
			count_q   <= '0;
			idx_q     <= '0;
			pend_q    <= 1'b0;
			fwd_q     <= 1'b0;
			arm_q     <= 1'b0;
			cval_q    <= '0;
			ptr_q     <= '0;
		end else begin
			if (cfg.valid) begin
				own_q <= cfg.own_node_id;
			end
			pend_q <= cmd.rd_en;
			if (capture) begin
				fwd_q <= 1'b0;
				arm_q <= 1'b0;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmd.tbl_clr) begin
				count_q <= '0;
				cval_q  <= '0;
				ptr_q   <= '0;
			end
			if (cmd.seq_adopt) begin
				cur_seq_q <= seq_in_q;
				fwd_q     <= 1'b1;
			end else if (cmd.seq_inc) begin
				cur_seq_q <= cur_seq_q + tfnt_pkg::SEQ_W'(1);
			end
			if (cmd.nbr_add && room) begin
				count_q <= count_q + CNT_W'(1);
				arm_q   <= 1'b1;
			end
			// a forwarded reply takes the next ring slot
			if (cmd.load && cmd.res_sel == tfnt_pkg::RES_PKT && is_reply && fwd_reply) begin
				cval_q[ptr_q] <= 1'b1;
				ptr_q <= (ptr_q == PTR_W'(ORIGIN_CACHE_SLOTS - 1)) ? '0 : ptr_q + PTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && cmd.res_sel == tfnt_pkg::RES_PKT && is_reply && fwd_reply) begin
			cache_q[ptr_q] <= org_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.load) begin
			ovalid_q <= 1'b1;
		end else if (res.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			onid_q   <= '0;
			ototal_q <= count_q;
			oarm_q   <= 1'b0;
			odelay_q <= '0;
			olast_q  <= 1'b1;
			oseq_q   <= cur_seq_q;
			oorg_q   <= own_q;
			orte_q   <= own_q;
			unique case (cmd.res_sel)
				tfnt_pkg::RES_PKT: begin
					oaction_q <= fwd ? tfnt_pkg::ACT_FWD : tfnt_pkg::ACT_NONE;
					oseq_q    <= fwd ? seq_in_q : '0;
					oorg_q    <= fwd ? org_q : '0;
					orte_q    <= fwd ? own_q : '0;
					oarm_q    <= arm_q;
					odelay_q  <= arm_q ? delay_q : '0;
				end
				tfnt_pkg::RES_START: begin
					oaction_q <= tfnt_pkg::ACT_PING;
				end
				tfnt_pkg::RES_HDR: begin
					oaction_q <= tfnt_pkg::ACT_HDR;
					olast_q   <= count_q == '0;
				end
				tfnt_pkg::RES_ENTRY: begin
					oaction_q <= tfnt_pkg::ACT_ENTRY;
					onid_q    <= rd_data;
					olast_q   <= sts.idx_last;
				end
			endcase
		end
	end

	assign res.valid          = ovalid_q;
	assign res.action         = oaction_q;
	assign res.seq_no_out     = oseq_q;
	assign res.origin_out     = oorg_q;
	assign res.route_out      = orte_q;
	assign res.neighbor_id    = onid_q;
	assign res.neighbor_total = ototal_q;
	assign res.arm_timer      = oarm_q;
	assign res.delay_ms       = odelay_q;
	assign res.last           = olast_q;

endmodule

/* hw/rtl/tfnt_ctrl.sv */
// ----------------------------------------------------------------------------
// tfnt_ctrl
// Controller: decodes one event, steps the neighbor scan and the reply dump.
// ----------------------------------------------------------------------------
module tfnt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  tfnt_pkg::tfnt_sts_t sts,
	output tfnt_pkg::tfnt_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_EMIT = 3'd3;
	localparam logic [2:0] S_HDR  = 3'd4;
	localparam logic [2:0] S_DRD  = 3'd5;
	localparam logic [2:0] S_DWR  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.take = 1'b1;
				if (sts.evt_valid) begin
					state_nxt = S_DEC;
				end
			end
			S_DEC: begin
				cmd.idx_clr = 1'b1;
				state_nxt   = S_IDLE;
				case (sts.command)
					tfnt_pkg::CMD_RX: begin
						if (sts.is_ping) begin
							if (sts.new_seq) begin
								cmd.tbl_clr   = 1'b1;
								cmd.seq_adopt = 1'b1;
							end
							state_nxt = S_SCAN;
						end else if (sts.is_reply) begin
							state_nxt = S_SCAN;
						end
					end
					tfnt_pkg::CMD_START: begin
						cmd.tbl_clr = 1'b1;
						cmd.seq_inc = 1'b1;
						state_nxt   = S_EMIT;
					end
					tfnt_pkg::CMD_TIMER: begin
						state_nxt = S_HDR;
					end
					default: begin
						state_nxt = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				// one table read issued per cycle, compared the cycle after
				if (sts.match) begin
					state_nxt = S_EMIT;
				end else if (!sts.idx_end) begin
					cmd.rd_en   = 1'b1;
					cmd.idx_inc = 1'b1;
				end else if (!sts.pend) begin
					cmd.nbr_add = 1'b1;
					state_nxt   = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.load    = 1'b1;
					cmd.res_sel = (sts.command == tfnt_pkg::CMD_START) ?
						tfnt_pkg::RES_START : tfnt_pkg::RES_PKT;
					state_nxt   = S_IDLE;
				end
			end
			S_HDR: begin
				if (sts.out_free) begin
					cmd.load    = 1'b1;
					cmd.res_sel = tfnt_pkg::RES_HDR;
					state_nxt   = sts.cnt_zero ? S_IDLE : S_DRD;
				end
			end
			S_DRD: begin
				cmd.rd_en = 1'b1;
				state_nxt = S_DWR;
			end
			S_DWR: begin
				if (sts.out_free) begin
					cmd.load    = 1'b1;
					cmd.res_sel = tfnt_pkg::RES_ENTRY;
					cmd.idx_inc = 1'b1;
					state_nxt   = sts.idx_last ? S_IDLE : S_DRD;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* hw/rtl/topology_flood_neighbor_tracker.sv */
// One event word is taken at a time. A received ping or reply scans the
// neighbor table for its sender and stops early when the sender is found,
// since the neighbor memory has one read port and is scanned one entry per
// cycle; a timer expiry makes one memory read and one output word for each
// neighbor. A finished word waits in the output register, and the next
// event is accepted while it waits.
// No clearing pass follows reset.
// ----------------------------------------------------------------------------
// topology_flood_neighbor_tracker
// Flood handling with duplicate suppression and neighbor tracking.
// ----------------------------------------------------------------------------
module topology_flood_neighbor_tracker #(
	parameter int NEIGHBOR_SLOTS     = tfnt_pkg::NEIGHBOR_SLOTS_DEF,
	parameter int ORIGIN_CACHE_SLOTS = tfnt_pkg::ORIGIN_CACHE_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tfnt_in_if.sink     evt,
	tfnt_cfg_if.sink    cfg,
	tfnt_out_if.source  res
);

	tfnt_pkg::tfnt_cmd_t cmd;
	tfnt_pkg::tfnt_sts_t sts;

	tfnt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	tfnt_dp #(
		.NEIGHBOR_SLOTS     (NEIGHBOR_SLOTS),
		.ORIGIN_CACHE_SLOTS (ORIGIN_CACHE_SLOTS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt),
		.cfg    (cfg),
		.res    (res),
		.cmd    (cmd),
		.sts    (sts)
	);

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && evt.ready |=> !evt.ready)
		else $error("event word accepted while another is in work");

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.neighbor_total <= NEIGHBOR_SLOTS)
		else $error("neighbor total beyond table size");

	a_delay_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.arm_timer |-> res.delay_ms >= tfnt_pkg::DELAY_BASE
			&& res.delay_ms < tfnt_pkg::DELAY_BASE + tfnt_pkg::DELAY_SPAN)
		else $error("reply delay out of range");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.nbr_add && cmd.rd_en))
		else $error("neighbor write and scan read in one cycle");

endmodule

/* verif/tb_topology_flood_neighbor_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_topology_flood_neighbor_tracker
// Self-checking bench for the flood neighbor tracker: a queue-fed driver pushes
// event words with random gaps, a monitor takes result words with random stalls
// and compares each one against a cycle-free predictor of the flood state.
// ----------------------------------------------------------------------------
module tb_topology_flood_neighbor_tracker;

	localparam int TOTAL_W       = $clog2(tfnt_pkg::NEIGHBOR_SLOTS_DEF + 1);
	localparam int SETTLE_CYCLES = 80;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int MAX_REPORTS   = 10;
	localparam logic [tfnt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [tfnt_pkg::CMD_W-1:0]  command;
		logic [tfnt_pkg::PKT_W-1:0]  pkt_type;
		logic [tfnt_pkg::SEQ_W-1:0]  seq_no;
		logic [tfnt_pkg::ID_W-1:0]   origin;
		logic [tfnt_pkg::ID_W-1:0]   route;
		logic [tfnt_pkg::RAND_W-1:0] random_value;
	} flood_event_t;

	typedef struct packed {
		logic [tfnt_pkg::ACT_W-1:0]   action;
		logic [tfnt_pkg::SEQ_W-1:0]   seq_no_out;
		logic [tfnt_pkg::ID_W-1:0]    origin_out;
		logic [tfnt_pkg::ID_W-1:0]    route_out;
		logic [tfnt_pkg::ID_W-1:0]    neighbor_id;
		logic [TOTAL_W-1:0]           neighbor_total;
		logic                         arm_timer;
		logic [tfnt_pkg::DELAY_W-1:0] delay_ms;
		logic                         last;
	} flood_word_t;

	logic clk;
	logic arst_n;

	tfnt_in_if  evt_if();
	tfnt_cfg_if cfg_if();
	tfnt_out_if res_if();

	topology_flood_neighbor_tracker i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_if),
		.cfg    (cfg_if),
		.res    (res_if)
	);

	// predicted node state
	logic [tfnt_pkg::ID_W-1:0]  own_id;
	logic [tfnt_pkg::SEQ_W-1:0] cur_seq;
	logic [tfnt_pkg::ID_W-1:0]  nbr_table [tfnt_pkg::NEIGHBOR_SLOTS_DEF];
	int                         nbr_count;
	logic [tfnt_pkg::ID_W-1:0]  seen_origins [tfnt_pkg::ORIGIN_CACHE_SLOTS_DEF];
	logic                       seen_valid [tfnt_pkg::ORIGIN_CACHE_SLOTS_DEF];
	int                         seen_ptr;

	flood_event_t pending_events [$];
	flood_word_t  expected_words [$];

	flood_event_t               drive_ev;
	flood_word_t                got_word;
	flood_word_t                want_word;
	logic [tfnt_pkg::SEQ_W-1:0] gen_seq;
	bit                         idle_enable;
	int                         gap_left;
	int                         gap_draw;
	int                         stall_left;
	int                         stall_draw;
	int                         cycle_count;
	int                         err_count;
	int                         events_taken;
	int                         words_checked;
	int                         queued_effective;
	int                         id_settings;
	int                         full_rejects;
	int                         replies_held;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic void clear_flood_state();
		nbr_count = 0;
		seen_ptr  = 0;
		for (int i = 0; i < tfnt_pkg::ORIGIN_CACHE_SLOTS_DEF; i++) begin
			seen_valid[i] = 1'b0;
		end
	endfunction

	function automatic bit add_neighbor(input logic [tfnt_pkg::ID_W-1:0] id);
		for (int i = 0; i < nbr_count; i++) begin
			if (nbr_table[i] == id) begin
				return 1'b0;
			end
		end
		if (nbr_count >= tfnt_pkg::NEIGHBOR_SLOTS_DEF) begin
			full_rejects++;
			return 1'b0;
		end
		nbr_table[nbr_count] = id;
		nbr_count++;
		return 1'b1;
	endfunction

	function automatic bit origin_seen(input logic [tfnt_pkg::ID_W-1:0] id);
		for (int i = 0; i < tfnt_pkg::ORIGIN_CACHE_SLOTS_DEF; i++) begin
			if (seen_valid[i] && seen_origins[i] == id) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void predict_flood(input flood_event_t ev);
		flood_word_t w;
		bit          armed;
		w = '0;
		case (ev.command)
			tfnt_pkg::CMD_RX: begin
				if (ev.pkt_type == tfnt_pkg::PKT_PING || ev.pkt_type == tfnt_pkg::PKT_REPLY) begin
					if (ev.pkt_type == tfnt_pkg::PKT_PING) begin
						// a new sequence number starts a fresh flood
						if (ev.seq_no != cur_seq) begin
							clear_flood_state();
							cur_seq      = ev.seq_no;
							w.action     = tfnt_pkg::ACT_FWD;
							w.seq_no_out = ev.seq_no;
							w.origin_out = ev.origin;
							w.route_out  = own_id;
						end
						armed = add_neighbor(ev.route);
					end else begin
						armed = add_neighbor(ev.route);
						if (ev.origin != own_id && !origin_seen(ev.origin)) begin
							seen_origins[seen_ptr] = ev.origin;
							seen_valid[seen_ptr]   = 1'b1;
							seen_ptr     = (seen_ptr + 1) % tfnt_pkg::ORIGIN_CACHE_SLOTS_DEF;
							w.action     = tfnt_pkg::ACT_FWD;
							w.seq_no_out = ev.seq_no;
							w.origin_out = ev.origin;
							w.route_out  = own_id;
						end else begin
							replies_held++;
						end
					end
					w.neighbor_total = TOTAL_W'(nbr_count);
					w.arm_timer      = armed;
					w.delay_ms       = armed ? tfnt_pkg::DELAY_W'(tfnt_pkg::DELAY_BASE +
						ev.random_value % tfnt_pkg::DELAY_SPAN) : '0;
					w.last           = 1'b1;
					expected_words.push_back(w);
				end
			end
			tfnt_pkg::CMD_START: begin
				clear_flood_state();
				cur_seq      = cur_seq + 1'b1;
				w.action     = tfnt_pkg::ACT_PING;
				w.seq_no_out = cur_seq;
				w.origin_out = own_id;
				w.route_out  = own_id;
				w.last       = 1'b1;
				expected_words.push_back(w);
			end
			tfnt_pkg::CMD_TIMER: begin
				w.action         = tfnt_pkg::ACT_HDR;
				w.seq_no_out     = cur_seq;
				w.origin_out     = own_id;
				w.route_out      = own_id;
				w.neighbor_total = TOTAL_W'(nbr_count);
				w.last           = (nbr_count == 0);
				expected_words.push_back(w);
				for (int i = 0; i < nbr_count; i++) begin
					w.action      = tfnt_pkg::ACT_ENTRY;
					w.neighbor_id = nbr_table[i];
					w.last        = (i == nbr_count - 1);
					expected_words.push_back(w);
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic string word_text(input flood_word_t w);
		return {$sformatf("action=%0d seq=%0d origin=%h route=%h nbr=%h ",
			w.action, w.seq_no_out, w.origin_out, w.route_out, w.neighbor_id),
			$sformatf("total=%0d arm=%0b delay=%0d last=%0b",
			w.neighbor_total, w.arm_timer, w.delay_ms, w.last)};
	endfunction

	function automatic void note_error(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS) begin
			$display("[%0t] %s", $realtime, msg);
		end
	endfunction

	function automatic int pace_draw();
		if (!idle_enable || $urandom_range(0, 3) == 0) begin
			return 0;
		end
		return $urandom_range(0, 7);
	endfunction

	// event driver
	always @(posedge clk) begin
		if (!arst_n) begin
			evt_if.valid <= 1'b0;
			gap_left     <= 0;
		end else if (evt_if.valid && evt_if.ready) begin
			predict_flood(drive_ev);
			events_taken++;
			gap_draw = pace_draw();
			if (gap_draw == 0 && pending_events.size() != 0) begin
				drive_ev = pending_events.pop_front();
				evt_if.command      <= drive_ev.command;
				evt_if.pkt_type     <= drive_ev.pkt_type;
				evt_if.seq_no       <= drive_ev.seq_no;
				evt_if.origin       <= drive_ev.origin;
				evt_if.route        <= drive_ev.route;
				evt_if.random_value <= drive_ev.random_value;
			end else begin
				evt_if.valid <= 1'b0;
				gap_left     <= (gap_draw > 0) ? gap_draw - 1 : 0;
			end
		end else if (!evt_if.valid) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
			end else if (pending_events.size() != 0) begin
				drive_ev = pending_events.pop_front();
				evt_if.valid        <= 1'b1;
				evt_if.command      <= drive_ev.command;
				evt_if.pkt_type     <= drive_ev.pkt_type;
				evt_if.seq_no       <= drive_ev.seq_no;
				evt_if.origin       <= drive_ev.origin;
				evt_if.route        <= drive_ev.route;
				evt_if.random_value <= drive_ev.random_value;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			stall_left   <= 0;
		end else if (res_if.valid && res_if.ready) begin
			got_word.action         = res_if.action;
			got_word.seq_no_out     = res_if.seq_no_out;
			got_word.origin_out     = res_if.origin_out;
			got_word.route_out      = res_if.route_out;
			got_word.neighbor_id    = res_if.neighbor_id;
			got_word.neighbor_total = res_if.neighbor_total;
			got_word.arm_timer      = res_if.arm_timer;
			got_word.delay_ms       = res_if.delay_ms;
			got_word.last           = res_if.last;
			if (expected_words.size() == 0) begin
				note_error($sformatf("result word with none expected: %s",
					word_text(got_word)));
			end else begin
				want_word = expected_words.pop_front();
				words_checked++;
				if (got_word !== want_word) begin
					note_error($sformatf("result word mismatch\n  expected %s\n  actual   %s",
						word_text(want_word), word_text(got_word)));
				end
			end
			stall_draw = pace_draw();
			if (stall_draw > 0) begin
				res_if.ready <= 1'b0;
				stall_left   <= stall_draw - 1;
			end
		end else if (!res_if.ready) begin
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	task automatic queue_event(input logic [tfnt_pkg::CMD_W-1:0] cmd,
		input logic [tfnt_pkg::PKT_W-1:0] pkt,
		input logic [tfnt_pkg::SEQ_W-1:0] seq, input logic [tfnt_pkg::ID_W-1:0] org,
		input logic [tfnt_pkg::ID_W-1:0] rte, input logic [tfnt_pkg::RAND_W-1:0] rnd);
		flood_event_t ev;
		ev = '{cmd, pkt, seq, org, rte, rnd};
		pending_events.push_back(ev);
		// track the flood sequence the block will hold, so rounds stay well formed
		if (cmd == tfnt_pkg::CMD_RX && pkt == tfnt_pkg::PKT_PING) begin
			gen_seq = seq;
		end else if (cmd == tfnt_pkg::CMD_START) begin
			gen_seq = gen_seq + 1'b1;
		end
		if (cmd == tfnt_pkg::CMD_START || cmd == tfnt_pkg::CMD_TIMER ||
			(cmd == tfnt_pkg::CMD_RX &&
			(pkt == tfnt_pkg::PKT_PING || pkt == tfnt_pkg::PKT_REPLY))) begin
			queued_effective++;
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_events.size() != 0 || evt_if.valid || expected_words.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_own_id(input logic [tfnt_pkg::ID_W-1:0] id);
		@(posedge clk);
		cfg_if.valid       <= 1'b1;
		cfg_if.own_node_id <= id;
		do @(posedge clk);
		while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		own_id = id;
		id_settings++;
		@(negedge clk);
	endtask

	// one flood: an opener in most rounds, a burst of traffic for that flood, then a reply dump
	task automatic add_round();
		logic [tfnt_pkg::ID_W-1:0]  nb_base;
		logic [tfnt_pkg::ID_W-1:0]  org_base;
		logic [tfnt_pkg::ID_W-1:0]  org;
		logic [tfnt_pkg::PKT_W-1:0] pkt;
		int                         kind;
		int                         n;
		int                         r;
		nb_base  = 16'($urandom);
		org_base = 16'($urandom);
		kind     = $urandom_range(0, 9);
		if (kind < 5) begin
			queue_event(tfnt_pkg::CMD_START, 8'($urandom), 8'($urandom), 16'($urandom),
				16'($urandom), 15'($urandom));
		end else if (kind < 9) begin
			queue_event(tfnt_pkg::CMD_RX, tfnt_pkg::PKT_PING,
				gen_seq + 8'($urandom_range(1, 255)),
				16'($urandom), nb_base, 15'($urandom));
		end
		if ($urandom_range(0, 5) == 0) begin
			// overfill the neighbor table and wrap the origin ring
			n = $urandom_range(30, 34);
			for (int i = 0; i < n; i++) begin
				queue_event(tfnt_pkg::CMD_RX, tfnt_pkg::PKT_REPLY, 8'($urandom),
					org_base + 16'(i), nb_base + 16'(i), 15'($urandom));
			end
			repeat (6) begin
				queue_event(tfnt_pkg::CMD_RX, tfnt_pkg::PKT_REPLY, 8'($urandom),
					org_base + 16'($urandom_range(0, n - 1)),
					nb_base + 16'($urandom_range(0, n + 3)), 15'($urandom));
			end
		end else begin
			n = $urandom_range(4, 16);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 40) begin
					queue_event(tfnt_pkg::CMD_RX, tfnt_pkg::PKT_PING, gen_seq,
						16'($urandom), nb_base + 16'($urandom_range(0, 39)),
						15'($urandom));
				end else if (r < 78) begin
					org = ($urandom_range(0, 19) == 0) ? own_id :
						org_base + 16'($urandom_range(0, 13));
					queue_event(tfnt_pkg::CMD_RX, tfnt_pkg::PKT_REPLY, 8'($urandom), org,
						nb_base + 16'($urandom_range(0, 39)), 15'($urandom));
				end else if (r < 83) begin
					queue_event(tfnt_pkg::CMD_RX, tfnt_pkg::PKT_PING,
						gen_seq + 8'($urandom_range(1, 255)), 16'($urandom),
						nb_base + 16'($urandom_range(0, 39)), 15'($urandom));
				end else if (r < 88) begin
					pkt = 8'($urandom);
					if (pkt == tfnt_pkg::PKT_PING || pkt == tfnt_pkg::PKT_REPLY) begin
						pkt = pkt ^ 8'h04;
					end
					queue_event(tfnt_pkg::CMD_RX, pkt, 8'($urandom), 16'($urandom),
						16'($urandom), 15'($urandom));
				end else if (r < 91) begin
					queue_event(CMD_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom),
						16'($urandom), 15'($urandom));
				end else if (r < 96) begin
					queue_event(tfnt_pkg::CMD_TIMER, 8'($urandom), 8'($urandom),
						16'($urandom), 16'($urandom), 15'($urandom));
				end else begin
					queue_event(tfnt_pkg::CMD_RX, ($urandom_range(0, 1) == 0) ?
						tfnt_pkg::PKT_PING : tfnt_pkg::PKT_REPLY,
						8'($urandom), 16'($urandom), 16'($urandom), 15'($urandom));
				end
			end
		end
		queue_event(tfnt_pkg::CMD_TIMER, 8'($urandom), 8'($urandom), 16'($urandom),
			16'($urandom), 15'($urandom));
	endtask

	task automatic add_random_phase(input int goal);
		int target;
		target = queued_effective + goal;
		while (queued_effective < target) begin
			add_round();
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		evt_if.valid        = 1'b0;
		evt_if.command      = tfnt_pkg::CMD_RX;
		evt_if.pkt_type     = '0;
		evt_if.seq_no       = '0;
		evt_if.origin       = '0;
		evt_if.route        = '0;
		evt_if.random_value = '0;
		cfg_if.valid        = 1'b0;
		cfg_if.own_node_id  = '0;
		res_if.ready        = 1'b0;
		own_id              = '0;
		cur_seq             = '0;
		gen_seq             = '0;
		idle_enable         = 1'b1;
		cycle_count         = 0;
		err_count           = 0;
		events_taken        = 0;
		words_checked       = 0;
		queued_effective    = 0;
		id_settings         = 0;
		full_rejects        = 0;
		replies_held        = 0;
		clear_flood_state();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_own_id(16'h0000);
		// empty table gives a lone header
		queue_event(tfnt_pkg::CMD_TIMER, 8'h00, 8'h00, 16'h0000, 16'h0000, 15'h0000);
		queue_event(tfnt_pkg::CMD_RX, tfnt_pkg::PKT_PING, 8'h00, 16'h0001, 16'h0001, 15'd0);
		queue_event(tfnt_pkg::CMD_RX, tfnt_pkg::PKT_PING, 8'h00, 16'h0002, 16'h0001,
			15'd499);
		queue_event(tfnt_pkg::CMD_RX, tfnt_pkg::PKT_PING, 8'h80, 16'hFFFF, 16'hFFFF,
			15'h7FFF);
		// reply from our own id is never forwarded
		queue_event(tfnt_pkg::CMD_RX, tfnt_pkg::PKT_REPLY, 8'h00, 16'h0000, 16'h0005,
			15'd500);
		queue_event(tfnt_pkg::CMD_RX, tfnt_pkg::PKT_REPLY, 8'hFF, 16'h1234, 16'h0000,
			15'd999);
		queue_event(tfnt_pkg::CMD_RX, tfnt_pkg::PKT_REPLY, 8'h55, 16'h1234, 16'hFFFF,
			15'd1000);
		queue_event(tfnt_pkg::CMD_RX, 8'h00, 8'hFF, 16'hFFFF, 16'hFFFF, 15'h7FFF);
		queue_event(tfnt_pkg::CMD_RX, 8'hFF, 8'h12, 16'h0BAD, 16'h0BAD, 15'h1234);
		queue_event(tfnt_pkg::CMD_RX, 8'h03, 8'h34, 16'h7777, 16'h7777, 15'h0001);
		queue_event(CMD_UNUSED, tfnt_pkg::PKT_PING, 8'hFF, 16'hFFFF, 16'hFFFF, 15'h7FFF);
		queue_event(tfnt_pkg::CMD_TIMER, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 15'h7FFF);
		// sequence 255 then start wraps the count to zero
		queue_event(tfnt_pkg::CMD_RX, tfnt_pkg::PKT_PING, 8'hFF, 16'hAAAA, 16'h5555,
			15'h2AAA);
		queue_event(tfnt_pkg::CMD_START, 8'h00, 8'h00, 16'h0000, 16'h0000, 15'h5555);
		queue_event(tfnt_pkg::CMD_TIMER, 8'h00, 8'h00, 16'h0000, 16'h0000, 15'h0000);
		queue_event(tfnt_pkg::CMD_RX, tfnt_pkg::PKT_PING, 8'h00, 16'h4321, 16'h8000,
			15'd501);
		queue_event(tfnt_pkg::CMD_RX, tfnt_pkg::PKT_REPLY, 8'h00, 16'h0001, 16'h8000,
			15'd32000);
		queue_event(tfnt_pkg::CMD_RX, tfnt_pkg::PKT_REPLY, 8'h01, 16'hFFFF, 16'h0001,
			15'd7);
		queue_event(tfnt_pkg::CMD_TIMER, 8'h00, 8'h00, 16'h0000, 16'h0000, 15'h0000);
		wait_drained();

		write_own_id(16'hFFFF);
		add_random_phase(120);
		wait_drained();

		idle_enable = 1'b0;
		write_own_id(16'($urandom));
		add_random_phase(120);
		wait_drained();

		idle_enable = 1'b1;
		write_own_id(16'($urandom));
		add_random_phase(120);
		wait_drained();

		if (expected_words.size() != 0) begin
			note_error($sformatf("%0d result words never arrived", expected_words.size()));
		end
		$display("Run: %0d events, %0d result words checked across %0d node id settings",
			events_taken, words_checked, id_settings);
		$display("Run: %0d arrivals refused by a full table, %0d replies held back",
			full_rejects, replies_held);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
